@@ hw/rtl/spsub_pkg.sv @@
package spsub_pkg;

  // list capacity and derived widths
  localparam int MAX_TERMS = 32;
  localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);

  // field widths fixed by the interface
  localparam int COEF_W  = 32;
  localparam int DCOEF_W = 33;
  localparam int EXP_W   = 16;
  localparam int TNUM_W  = 7;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_START  = 2'd2
  } opcode_t;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic advance;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic exhausted;
    logic slot_free;
  } stat_t;

endpackage

@@ hw/rtl/spsub_if.sv @@
interface spsub_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            opcode;
  logic signed [spsub_pkg::COEF_W-1:0]   coef;
  logic [spsub_pkg::EXP_W-1:0]           expon;

  modport source (output valid, opcode, coef, expon, input ready);
  modport sink   (input valid, opcode, coef, expon, output ready);
endinterface

interface spsub_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [spsub_pkg::DCOEF_W-1:0]  diff_coef;
  logic [spsub_pkg::EXP_W-1:0]           diff_expon;
  logic [spsub_pkg::TNUM_W-1:0]          term_number;
  logic                                  last;
  logic                                  empty_res;
  logic                                  overflowed;

  modport source (output valid, diff_coef, diff_expon, term_number, last, empty_res,
                  overflowed, input ready);
  modport sink   (input valid, diff_coef, diff_expon, term_number, last, empty_res,
                  overflowed, output ready);
endinterface

@@ hw/rtl/sparse_polynomial_subtract_core.sv @@
// Sparse polynomial subtractor. Opcode 0 and 1 transfers load one term of A or B
// (coefficient, exponent) at one transfer per cycle while no run is in progress;
// each list holds MAX_TERMS terms and extra loads are dropped and reported through
// the overflowed bit. Lists are expected in descending exponent order; no order
// check is made. A start transfer merges the lists into A - B: equal exponents
// subtract, zero differences vanish and leftover B terms are negated. Result terms
// leave in merge order with a one-based term number and last on the final one; an
// empty difference gives a single result with empty_res and last set. The merge
// consumes one head term of A or B (or one of each on equal exponents) per cycle
// while the result side accepts, reading each term store through its single read
// port. No load or start is taken while a run is in progress; both lists and the
// overflow flag are empty again when the run ends. Opcode 3 is ignored.
module sparse_polynomial_subtract_core (
  input  logic        clk,
  input  logic        rst_n,
  spsub_in_if.sink    in_ch,
  spsub_out_if.source out_ch
);

  spsub_pkg::cmd_t  cmd;
  spsub_pkg::stat_t stat;

  // sequencer: idle/load phase versus merge phase
  spsub_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // term stores, merge compare/subtract and result register
  spsub_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_coef         (in_ch.coef),
    .in_expon        (in_ch.expon),
    .stat            (stat),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_diff_coef   (out_ch.diff_coef),
    .out_diff_expon  (out_ch.diff_expon),
    .out_term_number (out_ch.term_number),
    .out_last        (out_ch.last),
    .out_empty_res   (out_ch.empty_res),
    .out_overflowed  (out_ch.overflowed)
  );

endmodule

@@ hw/rtl/spsub_ctrl.sv @@
module spsub_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_opcode,
  output logic               in_ready,
  input  spsub_pkg::stat_t   stat,
  output spsub_pkg::cmd_t    cmd
);

  spsub_pkg::state_t state_r;
  spsub_pkg::state_t state_nxt;
  logic              in_xfer;
  logic              is_load_a;
  logic              is_load_b;
  logic              is_start;

  assign in_xfer = in_valid && in_ready;

  // opcode decode
  always_comb begin
    is_load_a = 1'b0;
    is_load_b = 1'b0;
    is_start  = 1'b0;
    unique case (spsub_pkg::opcode_t'(in_opcode))
      spsub_pkg::OP_LOAD_A: is_load_a = 1'b1;
      spsub_pkg::OP_LOAD_B: is_load_b = 1'b1;
      spsub_pkg::OP_START:  is_start  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spsub_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spsub_pkg::ST_IDLE: begin
        if (in_xfer && is_start) state_nxt = spsub_pkg::ST_MERGE;
      end
      spsub_pkg::ST_MERGE: begin
        if (stat.slot_free && stat.exhausted) state_nxt = spsub_pkg::ST_IDLE;
      end
      default: state_nxt = spsub_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd.load_a  = 1'b0;
    cmd.load_b  = 1'b0;
    cmd.advance = 1'b0;
    cmd.finish  = 1'b0;
    unique case (state_r)
      spsub_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.load_a = in_valid && is_load_a;
        cmd.load_b = in_valid && is_load_b;
      end
      spsub_pkg::ST_MERGE: begin
        cmd.advance = stat.slot_free && !stat.exhausted;
        cmd.finish  = stat.slot_free && stat.exhausted;
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/spsub_dp.sv @@
module spsub_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  spsub_pkg::cmd_t                       cmd,
  input  logic signed [spsub_pkg::COEF_W-1:0]   in_coef,
  input  logic [spsub_pkg::EXP_W-1:0]           in_expon,
  output spsub_pkg::stat_t                      stat,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [spsub_pkg::DCOEF_W-1:0]  out_diff_coef,
  output logic [spsub_pkg::EXP_W-1:0]           out_diff_expon,
  output logic [spsub_pkg::TNUM_W-1:0]          out_term_number,
  output logic                                  out_last,
  output logic                                  out_empty_res,
  output logic                                  out_overflowed
);

  localparam int IW = spsub_pkg::IDX_W;
  localparam int CW = spsub_pkg::CNT_W;
  localparam logic signed [spsub_pkg::DCOEF_W-1:0] DCOEF_ZERO = '0;

  // term stores
  logic [spsub_pkg::COEF_W-1:0] a_coef_mem  [spsub_pkg::MAX_TERMS];
  logic [spsub_pkg::EXP_W-1:0]  a_expon_mem [spsub_pkg::MAX_TERMS];
  logic [spsub_pkg::COEF_W-1:0] b_coef_mem  [spsub_pkg::MAX_TERMS];
  logic [spsub_pkg::EXP_W-1:0]  b_expon_mem [spsub_pkg::MAX_TERMS];

  logic [CW-1:0] a_cnt_r, a_cnt_nxt;
  logic [CW-1:0] b_cnt_r, b_cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] ia_r, ia_nxt;
  logic [CW-1:0] ib_r, ib_nxt;

  logic [spsub_pkg::COEF_W-1:0] a_rd_coef_r, b_rd_coef_r;
  logic [spsub_pkg::EXP_W-1:0]  a_rd_expon_r, b_rd_expon_r;

  // one term held back so the final one can be flagged
  logic                                pend_v_r, pend_v_nxt;
  logic signed [spsub_pkg::DCOEF_W-1:0] pend_coef_r, pend_coef_nxt;
  logic [spsub_pkg::EXP_W-1:0]         pend_expon_r, pend_expon_nxt;
  logic [spsub_pkg::TNUM_W-1:0]        pend_num_r, pend_num_nxt;
  logic [spsub_pkg::TNUM_W-1:0]        k_r, k_nxt;

  logic                                out_valid_r, out_valid_nxt;
  logic signed [spsub_pkg::DCOEF_W-1:0] out_coef_r, out_coef_nxt;
  logic [spsub_pkg::EXP_W-1:0]         out_expon_r, out_expon_nxt;
  logic [spsub_pkg::TNUM_W-1:0]        out_num_r, out_num_nxt;
  logic                                out_last_r, out_last_nxt;
  logic                                out_empty_r, out_empty_nxt;
  logic                                out_ovf_r, out_ovf_nxt;

  logic                                a_has, b_has, take_a, take_b, produce;
  logic signed [spsub_pkg::DCOEF_W-1:0] a_ext, b_ext, term_coef;
  logic [spsub_pkg::EXP_W-1:0]         term_expon;
  logic                                a_full, b_full;

  assign a_has  = ia_r < a_cnt_r;
  assign b_has  = ib_r < b_cnt_r;
  assign a_full = a_cnt_r >= CW'(spsub_pkg::MAX_TERMS);
  assign b_full = b_cnt_r >= CW'(spsub_pkg::MAX_TERMS);
  assign a_ext  = {a_rd_coef_r[spsub_pkg::COEF_W-1], a_rd_coef_r};
  assign b_ext  = {b_rd_coef_r[spsub_pkg::COEF_W-1], b_rd_coef_r};

  assign stat.exhausted = !a_has && !b_has;
  assign stat.slot_free = !out_valid_r || out_ready;

  // merge decision on the current head terms
  always_comb begin
    take_a     = a_has && (!b_has || (a_rd_expon_r > b_rd_expon_r));
    take_b     = !take_a && (!a_has || (b_rd_expon_r > a_rd_expon_r));
    term_expon = take_b ? b_rd_expon_r : a_rd_expon_r;
    if (take_a) begin
      term_coef = a_ext;
    end else if (take_b) begin
      term_coef = DCOEF_ZERO - b_ext;
    end else begin
      term_coef = a_ext - b_ext;
    end
    produce = take_a || take_b || (term_coef != DCOEF_ZERO);
  end

  always_comb begin
    a_cnt_nxt      = a_cnt_r;
    b_cnt_nxt      = b_cnt_r;
    ovf_nxt        = ovf_r;
    ia_nxt         = ia_r;
    ib_nxt         = ib_r;
    pend_v_nxt     = pend_v_r;
    pend_coef_nxt  = pend_coef_r;
    pend_expon_nxt = pend_expon_r;
    pend_num_nxt   = pend_num_r;
    k_nxt          = k_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_coef_nxt   = out_coef_r;
    out_expon_nxt  = out_expon_r;
    out_num_nxt    = out_num_r;
    out_last_nxt   = out_last_r;
    out_empty_nxt  = out_empty_r;
    out_ovf_nxt    = out_ovf_r;

    if (cmd.load_a) begin
      if (a_full) ovf_nxt = 1'b1;
      else        a_cnt_nxt = a_cnt_r + CW'(1);
    end
    if (cmd.load_b) begin
      if (b_full) ovf_nxt = 1'b1;
      else        b_cnt_nxt = b_cnt_r + CW'(1);
    end

    if (cmd.advance) begin
      if (take_a || !take_b) ia_nxt = ia_r + CW'(1);
      if (take_b || !take_a) ib_nxt = ib_r + CW'(1);
      if (produce) begin
        // previous held term is known not to be the final one
        if (pend_v_r) begin
          out_valid_nxt = 1'b1;
          out_coef_nxt  = pend_coef_r;
          out_expon_nxt = pend_expon_r;
          out_num_nxt   = pend_num_r;
          out_last_nxt  = 1'b0;
          out_empty_nxt = 1'b0;
          out_ovf_nxt   = ovf_r;
        end
        pend_v_nxt     = 1'b1;
        pend_coef_nxt  = term_coef;
        pend_expon_nxt = term_expon;
        pend_num_nxt   = k_r + spsub_pkg::TNUM_W'(1);
        k_nxt          = k_r + spsub_pkg::TNUM_W'(1);
      end
    end

    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b1;
      out_ovf_nxt   = ovf_r;
      if (pend_v_r) begin
        out_coef_nxt  = pend_coef_r;
        out_expon_nxt = pend_expon_r;
        out_num_nxt   = pend_num_r;
        out_empty_nxt = 1'b0;
      end else begin
        out_coef_nxt  = DCOEF_ZERO;
        out_expon_nxt = '0;
        out_num_nxt   = '0;
        out_empty_nxt = 1'b1;
      end
      a_cnt_nxt  = '0;
      b_cnt_nxt  = '0;
      ovf_nxt    = 1'b0;
      ia_nxt     = '0;
      ib_nxt     = '0;
      pend_v_nxt = 1'b0;
      k_nxt      = '0;
    end
  end

  // store writes and prefetching reads
  always_ff @(posedge clk) begin
    if (cmd.load_a && !a_full) begin
      a_coef_mem[a_cnt_r[IW-1:0]]  <= in_coef;
      a_expon_mem[a_cnt_r[IW-1:0]] <= in_expon;
    end
    if (cmd.load_b && !b_full) begin
      b_coef_mem[b_cnt_r[IW-1:0]]  <= in_coef;
      b_expon_mem[b_cnt_r[IW-1:0]] <= in_expon;
    end
    a_rd_coef_r  <= a_coef_mem[ia_nxt[IW-1:0]];
    a_rd_expon_r <= a_expon_mem[ia_nxt[IW-1:0]];
    b_rd_coef_r  <= b_coef_mem[ib_nxt[IW-1:0]];
    b_rd_expon_r <= b_expon_mem[ib_nxt[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_cnt_r     <= '0;
      b_cnt_r     <= '0;
      ovf_r       <= 1'b0;
      ia_r        <= '0;
      ib_r        <= '0;
      pend_v_r    <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      a_cnt_r     <= a_cnt_nxt;
      b_cnt_r     <= b_cnt_nxt;
      ovf_r       <= ovf_nxt;
      ia_r        <= ia_nxt;
      ib_r        <= ib_nxt;
      pend_v_r    <= pend_v_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_coef_r  <= pend_coef_nxt;
    pend_expon_r <= pend_expon_nxt;
    pend_num_r   <= pend_num_nxt;
    out_coef_r   <= out_coef_nxt;
    out_expon_r  <= out_expon_nxt;
    out_num_r    <= out_num_nxt;
    out_last_r   <= out_last_nxt;
    out_empty_r  <= out_empty_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_diff_coef   = out_coef_r;
  assign out_diff_expon  = out_expon_r;
  assign out_term_number = out_num_r;
  assign out_last        = out_last_r;
  assign out_empty_res   = out_empty_r;
  assign out_overflowed  = out_ovf_r;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  // opcode 3 is not part of the command set; the block must ignore it
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam int ITEM_TARGET  = 400;
  localparam int STALL_LIMIT  = 2000;  // cycles with no transfer on either side
  localparam int DRAIN_CYCLES = 80;    // a full merge plus slack
  localparam int LONG_HOLD    = 300;   // receiver back-pressure stretch
  localparam int MAX_REPORTS  = 30;

  // one command for the input side, with the idle gap in front of it
  typedef struct {
    logic [1:0]  op;
    logic [31:0] coef;
    logic [15:0] expon;
    int          gap;
  } poly_cmd_t;

  // one term of the difference as it should leave the block
  typedef struct packed {
    logic signed [32:0] coef;
    logic [15:0]        expon;
    logic [6:0]         number;
    logic               last;
    logic               empty;
    logic               ovf;
  } diff_term_t;

  logic clk = 1'b0;
  logic rst_n;

  spsub_in_if  in_ch ();
  spsub_out_if out_ch ();

  sparse_polynomial_subtract_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // commands waiting for the driver, and terms waiting for the block
  poly_cmd_t  cmd_queue [$];
  diff_term_t diff_terms_due [$];

  // shadow copy of the two term lists
  logic signed [31:0] a_coef [spsub_pkg::MAX_TERMS];
  logic [15:0]        a_exp  [spsub_pkg::MAX_TERMS];
  logic signed [31:0] b_coef [spsub_pkg::MAX_TERMS];
  logic [15:0]        b_exp  [spsub_pkg::MAX_TERMS];
  int                 a_len = 0;
  int                 b_len = 0;
  logic               dropped_load = 1'b0;

  // handshake state seen at the last rising edge
  bit live     = 1'b0;
  bit in_fire  = 1'b0;
  bit out_fire = 1'b0;
  int idle_cycles = 0;

  // driver state
  poly_cmd_t cur;
  bit        have_cur = 1'b0;
  int        tx_calm  = 0;

  // bookkeeping for the summary
  int errors         = 0;
  int cmds_queued    = 0;
  int loads_taken    = 0;
  int starts_taken   = 0;
  int ignored_taken  = 0;
  int terms_checked  = 0;
  int empty_runs     = 0;
  int overflow_runs  = 0;
  int longest_run    = 0;

  // ---------------------------------------------------------------------------
  // expected behavior
  // ---------------------------------------------------------------------------

  // queue one difference term; last is patched in once the merge is done
  function automatic void emit_diff_term(logic signed [32:0] coef, logic [15:0] expon,
                                         int k);
    diff_term_t t;
    t.coef   = coef;
    t.expon  = expon;
    t.number = 7'(k + 1);
    t.last   = 1'b0;
    t.empty  = 1'b0;
    t.ovf    = dropped_load;
    diff_terms_due.push_back(t);
  endfunction

  // update the shadow lists for one accepted command, or merge them into A - B
  function automatic void apply_poly_cmd(logic [1:0] op, logic [31:0] coef,
                                         logic [15:0] expon);
    int ia;
    int ib;
    int k;
    logic signed [32:0] ca;
    logic signed [32:0] cb;
    diff_term_t t;
    ia = 0;
    ib = 0;
    k  = 0;
    case (op)
      spsub_pkg::OP_LOAD_A: begin
        loads_taken++;
        if (a_len >= spsub_pkg::MAX_TERMS) begin
          dropped_load = 1'b1;
        end else begin
          a_coef[a_len] = coef;
          a_exp[a_len]  = expon;
          a_len++;
        end
      end
      spsub_pkg::OP_LOAD_B: begin
        loads_taken++;
        if (b_len >= spsub_pkg::MAX_TERMS) begin
          dropped_load = 1'b1;
        end else begin
          b_coef[b_len] = coef;
          b_exp[b_len]  = expon;
          b_len++;
        end
      end
      spsub_pkg::OP_START: begin
        starts_taken++;
        if (dropped_load) overflow_runs++;
        // classic two-pointer merge on the heads of both lists
        while (ia < a_len || ib < b_len) begin
          if (ia < a_len && (ib >= b_len || a_exp[ia] > b_exp[ib])) begin
            ca = a_coef[ia];
            emit_diff_term(ca, a_exp[ia], k);
            k++;
            ia++;
          end else if (ia >= a_len || b_exp[ib] > a_exp[ia]) begin
            // term only in B, so it goes out negated
            cb = b_coef[ib];
            emit_diff_term(-cb, b_exp[ib], k);
            k++;
            ib++;
          end else begin
            ca = a_coef[ia];
            cb = b_coef[ib];
            // a zero difference vanishes from the result
            if (ca != cb) begin
              emit_diff_term(ca - cb, a_exp[ia], k);
              k++;
            end
            ia++;
            ib++;
          end
        end
        if (k == 0) begin
          // nothing left: a single marker term
          t.coef   = '0;
          t.expon  = '0;
          t.number = '0;
          t.last   = 1'b1;
          t.empty  = 1'b1;
          t.ovf    = dropped_load;
          diff_terms_due.push_back(t);
          empty_runs++;
        end else begin
          diff_terms_due[diff_terms_due.size() - 1].last = 1'b1;
        end
        if (k > longest_run) longest_run = k;
        a_len = 0;
        b_len = 0;
        dropped_load = 1'b0;
      end
      default: begin
        ignored_taken++;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // sampling at the rising edge: prediction, checking and the watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    diff_term_t got;
    diff_term_t want;
    live     = (rst_n === 1'b1);
    in_fire  = live && in_ch.valid && (in_ch.ready === 1'b1);
    out_fire = live && out_ch.ready && (out_ch.valid === 1'b1);

    if (in_fire) apply_poly_cmd(in_ch.opcode, in_ch.coef, in_ch.expon);

    if (out_fire) begin
      got.coef   = out_ch.diff_coef;
      got.expon  = out_ch.diff_expon;
      got.number = out_ch.term_number;
      got.last   = out_ch.last;
      got.empty  = out_ch.empty_res;
      got.ovf    = out_ch.overflowed;
      if (diff_terms_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected coef %0d expon %0d num %0d last %b empty %b ovf %b",
                   $time, got.coef, got.expon, got.number, got.last, got.empty, got.ovf);
      end else begin
        want = diff_terms_due.pop_front();
        terms_checked++;
        if (got !== want) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: expected coef %0d expon %0d num %0d last %b empty %b ovf %b",
                     $time, want.coef, want.expon, want.number, want.last, want.empty,
                     want.ovf);
            $display("%0t:   actual coef %0d expon %0d num %0d last %b empty %b ovf %b",
                     $time, got.coef, got.expon, got.number, got.last, got.empty,
                     got.ovf);
          end
        end
      end
    end

    // watchdog on transfers in either direction
    if (!live || in_fire || out_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d terms still due", $time, idle_cycles,
               diff_terms_due.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driver: inputs change at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!live) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !in_fire)) begin
      // previous transfer done (or nothing offered), move on
      if (!have_cur && cmd_queue.size() != 0) begin
        cur = cmd_queue.pop_front();
        have_cur = 1'b1;
      end
      if (have_cur && cur.gap == 0) begin
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= cur.op;
        in_ch.coef   <= cur.coef;
        in_ch.expon  <= cur.expon;
        have_cur = 1'b0;
      end else begin
        in_ch.valid <= 1'b0;
        if (have_cur) cur.gap--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls per term, calm stretches, and one long hold
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    int  rx_wait;
    int  rx_calm;
    int  long_hold;
    bit  long_hold_done;
    if (!live) begin
      out_ch.ready <= 1'b0;
      rx_wait = 0;
      rx_calm = 0;
      long_hold = 0;
      long_hold_done = 1'b0;
    end else if (long_hold > 0) begin
      out_ch.ready <= 1'b0;
      long_hold--;
    end else if (!long_hold_done && out_ch.valid && out_ch.term_number >= 20) begin
      // stall deep inside a long run so the block backs up onto its input
      long_hold_done = 1'b1;
      long_hold = LONG_HOLD - 1;
      out_ch.ready <= 1'b0;
    end else begin
      if (out_fire) begin
        if (rx_calm > 0) begin
          rx_wait = 0;
          rx_calm--;
        end else begin
          rx_wait = $urandom_range(0, 11);
          if ($urandom_range(0, 19) == 0) rx_calm = $urandom_range(15, 40);
        end
      end
      if (rx_wait > 0) begin
        out_ch.ready <= 1'b0;
        rx_wait--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // queue one command with its leading gap; stretches of back-to-back transfers
  function automatic void push_cmd(logic [1:0] op, logic [31:0] coef, logic [15:0] expon);
    poly_cmd_t c;
    c.op    = op;
    c.coef  = coef;
    c.expon = expon;
    if (tx_calm > 0) begin
      c.gap = 0;
      tx_calm--;
    end else begin
      c.gap = $urandom_range(0, 11);
      if ($urandom_range(0, 24) == 0) tx_calm = $urandom_range(15, 40);
    end
    cmd_queue.push_back(c);
    if (op != OP_RESERVED) cmds_queued++;
  endfunction

  // list length: mostly short, sometimes full, now and then past capacity
  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 19);
    if (r < 13) return $urandom_range(0, 6);
    if (r < 17) return $urandom_range(7, spsub_pkg::MAX_TERMS - 1);
    if (r < 19) return spsub_pkg::MAX_TERMS;
    return $urandom_range(spsub_pkg::MAX_TERMS + 1, spsub_pkg::MAX_TERMS + 4);
  endfunction

  function automatic int pick_expon(bit narrow);
    int r;
    if (narrow) return $urandom_range(0, 63);
    r = $urandom_range(0, 15);
    if (r == 0) return 65535;
    if (r == 1) return 0;
    return $urandom_range(0, 65535);
  endfunction

  function automatic logic [31:0] pick_coef();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 32'h7fff_ffff;
    if (r == 1) return 32'h8000_0000;
    if (r == 2) return 32'($urandom_range(0, 20)) - 32'd10;
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int          a_e [$];
    logic [31:0] a_c [$];
    int          b_e [$];
    logic [31:0] b_c [$];
    int          na;
    int          nb;
    int          ia;
    int          ib;
    int          j;
    int          k;
    bit          narrow;
    bit          ordered;
    bit          first_seq;

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.opcode = spsub_pkg::OP_LOAD_A;
    in_ch.coef   = '0;
    in_ch.expon  = '0;
    out_ch.ready = 1'b0;

    // directed: empty difference straight after reset
    push_cmd(spsub_pkg::OP_START, 32'h0, 16'h0);

    // directed: coefficient extremes, exact 33-bit results, a cancelling pair at 0
    push_cmd(spsub_pkg::OP_LOAD_A, 32'h7fff_ffff, 16'hffff);
    push_cmd(spsub_pkg::OP_LOAD_A, 32'h8000_0000, 16'd100);
    push_cmd(spsub_pkg::OP_LOAD_A, 32'd5, 16'd0);
    push_cmd(spsub_pkg::OP_LOAD_B, 32'h8000_0000, 16'hffff);
    push_cmd(spsub_pkg::OP_LOAD_B, 32'h7fff_ffff, 16'd100);
    push_cmd(spsub_pkg::OP_LOAD_B, 32'd5, 16'd0);
    push_cmd(spsub_pkg::OP_START, $urandom, 16'($urandom));

    // directed: B only, so every term is negated, most negative included
    push_cmd(spsub_pkg::OP_LOAD_B, 32'h8000_0000, 16'd7);
    push_cmd(spsub_pkg::OP_LOAD_B, 32'd1, 16'd3);
    push_cmd(spsub_pkg::OP_START, 32'h0, 16'h0);

    // directed: zero coefficient in A passes through; reserved opcode is ignored
    push_cmd(spsub_pkg::OP_LOAD_A, 32'd0, 16'd9);
    push_cmd(OP_RESERVED, 32'hffff_ffff, 16'hffff);
    push_cmd(spsub_pkg::OP_START, 32'h0, 16'h0);

    // directed: everything cancels, giving the empty marker again
    push_cmd(spsub_pkg::OP_LOAD_A, 32'd42, 16'd12);
    push_cmd(spsub_pkg::OP_LOAD_B, 32'd42, 16'd12);
    push_cmd(spsub_pkg::OP_START, 32'h0, 16'h0);

    // directed: lists loaded out of order, merged as they stand
    push_cmd(spsub_pkg::OP_LOAD_A, 32'd1, 16'd5);
    push_cmd(spsub_pkg::OP_LOAD_A, 32'd2, 16'd10);
    push_cmd(spsub_pkg::OP_LOAD_B, 32'd3, 16'd7);
    push_cmd(spsub_pkg::OP_START, 32'h0, 16'h0);

    // random polynomial pairs; the first is two full lists for a long run
    first_seq = 1'b1;
    while (cmds_queued < ITEM_TARGET) begin
      na = first_seq ? spsub_pkg::MAX_TERMS : pick_size();
      nb = first_seq ? spsub_pkg::MAX_TERMS : pick_size();
      first_seq = 1'b0;
      narrow  = ($urandom_range(0, 2) == 0);
      ordered = ($urandom_range(0, 9) != 0);
      a_e.delete();
      a_c.delete();
      b_e.delete();
      b_c.delete();
      for (j = 0; j < na; j++) begin
        a_e.push_back(pick_expon(narrow));
        a_c.push_back(pick_coef());
      end
      if (ordered) a_e.rsort();
      // about half of B shares an exponent with A
      for (j = 0; j < nb; j++) begin
        if (na > 0 && $urandom_range(0, 1)) b_e.push_back(a_e[$urandom_range(0, na - 1)]);
        else b_e.push_back(pick_expon(narrow));
      end
      if (ordered) b_e.rsort();
      for (j = 0; j < nb; j++) begin
        b_c.push_back(pick_coef());
        // sometimes copy the matching A coefficient so the pair cancels
        if ($urandom_range(0, 2) == 0)
          for (k = 0; k < na; k++)
            if (a_e[k] == b_e[j]) b_c[j] = a_c[k];
      end
      // interleave the two lists, keeping the order within each
      ia = 0;
      ib = 0;
      while (ia < na || ib < nb) begin
        if (ib >= nb || (ia < na && $urandom_range(0, 1))) begin
          push_cmd(spsub_pkg::OP_LOAD_A, a_c[ia], 16'(a_e[ia]));
          ia++;
        end else begin
          push_cmd(spsub_pkg::OP_LOAD_B, b_c[ib], 16'(b_e[ib]));
          ib++;
        end
        if ($urandom_range(0, 39) == 0) push_cmd(OP_RESERVED, $urandom, 16'($urandom));
      end
      push_cmd(spsub_pkg::OP_START, $urandom, 16'($urandom));
    end

    // release reset at a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // all commands out, then all terms back, then a quiet tail
    while (cmd_queue.size() != 0 || have_cur || in_ch.valid) @(posedge clk);
    while (diff_terms_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d loads, %0d starts and %0d reserved opcodes; %0d terms checked",
             loads_taken, starts_taken, ignored_taken, terms_checked);
    $display("%0d empty differences, %0d runs after a dropped load, longest run %0d terms",
             empty_runs, overflow_runs, longest_run);
    if (errors == 0 && diff_terms_due.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
